// ===== rtl/clipped_blit_setup_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Clipped blit setup - assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_BLIT_SETUP_UNIT_MACROS_SVH
`define CLIPPED_BLIT_SETUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define CBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expr must never be true outside reset
`define CBS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define CBS_ASSERT(lbl, clk, rst, prop, msg)
`define CBS_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/cbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Clipped blit setup - package
// Payload, configuration and per-axis clip types shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

   localparam int BYTES_PER_PIXEL = 2;

   typedef enum logic [1:0] {
      CSR_DST_BASE   = 2'd0,
      CSR_DST_WIDTH  = 2'd1,
      CSR_DST_HEIGHT = 2'd2,
      CSR_DST_STRIDE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        src_base;
      logic [12:0]        src_width;
      logic [12:0]        src_height;
      logic [15:0]        src_stride;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               centered;
   } req_payload_type;

   typedef struct packed {
      logic        visible;
      logic [31:0] dst_start;
      logic [31:0] src_start;
      logic [13:0] row_bytes;
      logic [12:0] row_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] dst_base;
      logic [12:0] dst_width;
      logic [12:0] dst_height;
      logic [15:0] dst_stride;
   } cfg_type;

   // Result of clipping one axis
   typedef struct packed {
      logic        ok;    // something left on this axis
      logic [12:0] lo;    // first destination coordinate kept
      logic [12:0] cnt;   // coordinates kept
      logic [15:0] off;   // offset into the source of the first one kept
   } axis_clip_type;

endpackage

`default_nettype wire

// ===== rtl/clipped_blit_setup_unit.sv =====
// ---------------------------------------------------------------------------
// Clipped blit setup unit
// Clips a 16 bpp source rectangle against the destination frame buffer.
// ---------------------------------------------------------------------------
// Takes one request per cycle while req_stall is low and returns one
// response per request, in order. The request lands in an input register,
// the clip and address math run in one combinational pass, and the response
// sits in an output register. A response-side stall reaches req_stall only
// when the input register is also full; an empty input register still takes
// a request while a finished response waits. Each response says whether
// anything of the rectangle is left; if so it gives the first destination
// and source byte addresses (modulo 2^32), the bytes per row and the row
// count, otherwise all of those are zero. Centered placement puts the source
// at (dst - src) / 2 on each axis, rounded toward zero. The destination
// registers must only be written while no request is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "clipped_blit_setup_unit_macros.svh"

module clipped_blit_setup_unit
   import cbs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,

   // response channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,

   // register write port
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_index_type   csr_index,
   input  logic [31:0]     csr_data
);

   // destination registers
   cfg_type         cfg_ff, cfg_in;

   // input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff,  s1_data_in;

   // output stage
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   logic            advance;     // input stage may move into the output stage
   logic            req_accept;
   axis_clip_type   clip_x;
   axis_clip_type   clip_y;
   rsp_payload_type calc;

   // ---- register writes ---------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DST_BASE:   cfg_in.dst_base   = csr_data;
            CSR_DST_WIDTH:  cfg_in.dst_width  = csr_data[12:0];
            CSR_DST_HEIGHT: cfg_in.dst_height = csr_data[12:0];
            CSR_DST_STRIDE: cfg_in.dst_stride = csr_data[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dst_base   <= 32'd0;
         cfg_ff.dst_width  <= 13'd640;
         cfg_ff.dst_height <= 13'd480;
         cfg_ff.dst_stride <= 16'd1280;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- handshake ---------------------------------------------------------
   // The output register frees up when it is empty or being taken.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   // Stall only if the input stage is full and cannot move on.
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      s1_data_in   = req_accept ? req_data : s1_data_ff;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (advance && s1_valid_ff) ? calc : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---- single-pass datapath ----------------------------------------------
   cbs_clip_axis u_clip_x (
      .pos      (s1_data_ff.pos_x),
      .src_len  (s1_data_ff.src_width),
      .dst_len  (cfg_ff.dst_width),
      .centered (s1_data_ff.centered),
      .clip     (clip_x)
   );

   cbs_clip_axis u_clip_y (
      .pos      (s1_data_ff.pos_y),
      .src_len  (s1_data_ff.src_height),
      .dst_len  (cfg_ff.dst_height),
      .centered (s1_data_ff.centered),
      .clip     (clip_y)
   );

   cbs_addr u_addr (
      .cfg        (cfg_ff),
      .src_base   (s1_data_ff.src_base),
      .src_stride (s1_data_ff.src_stride),
      .clip_x     (clip_x),
      .clip_y     (clip_y),
      .rsp        (calc)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks ------------------------------------------------------------
   // A hidden response carries no copy sizes
   `CBS_ASSERT(a_hidden_zero, clock, reset,
      (rsp_valid_ff && !rsp_data_ff.visible) |->
         (rsp_data_ff.row_bytes == 14'd0 && rsp_data_ff.row_count == 13'd0),
      "hidden response with nonzero size")
   // A visible response always copies something
   `CBS_ASSERT(a_visible_size, clock, reset,
      (rsp_valid_ff && rsp_data_ff.visible) |->
         (rsp_data_ff.row_bytes != 14'd0 && rsp_data_ff.row_count != 13'd0),
      "visible response with empty size")
   // A full input stage that may advance fills the output register
   `CBS_ASSERT(a_advance, clock, reset, (s1_valid_ff && advance) |=> rsp_valid_ff,
      "request lost between stages")
   // Back-pressure only with a full input stage and a blocked output
   `CBS_ASSERT_NEVER(a_stall_cause, clock, reset,
      req_stall && !(s1_valid_ff && rsp_valid_ff && rsp_stall), "stall without cause")

endmodule

`default_nettype wire

// ===== rtl/cbs_clip_axis.sv =====
// ---------------------------------------------------------------------------
// Clipped blit setup - axis clipper
// Picks the placement on one axis and clips the span against the limit.
// ---------------------------------------------------------------------------
`default_nettype none

module cbs_clip_axis
   import cbs_pkg::*;
(
   input  logic signed [15:0] pos,
   input  logic        [12:0] src_len,
   input  logic        [12:0] dst_len,
   input  logic               centered,
   output axis_clip_type      clip
);

   logic signed [13:0] diff;
   logic signed [13:0] half;
   logic signed [17:0] start;
   logic signed [17:0] last;
   logic signed [17:0] lim_last;
   logic signed [17:0] lo_s;
   logic signed [17:0] hi_s;
   logic signed [17:0] cnt_s;
   logic signed [17:0] neg_start;

   always_comb begin
      // (dst - src) / 2, rounded toward zero
      diff      = $signed({1'b0, dst_len}) - $signed({1'b0, src_len});
      half      = (diff + $signed({13'd0, diff[13]})) >>> 1;
      start     = centered ? {{4{half[13]}}, half} : {{2{pos[15]}}, pos};
      last      = start + $signed({5'd0, src_len}) - 18'sd1;
      lim_last  = $signed({5'd0, dst_len}) - 18'sd1;
      lo_s      = start[17] ? 18'sd0 : start;
      hi_s      = (last > lim_last) ? lim_last : last;
      cnt_s     = hi_s - lo_s + 18'sd1;
      neg_start = -start;

      clip.ok  = (src_len != 13'd0) && (dst_len != 13'd0) &&
                 !(lo_s > lim_last) && !last[17];
      clip.lo  = lo_s[12:0];
      clip.cnt = cnt_s[12:0];
      clip.off = start[17] ? neg_start[15:0] : 16'd0;
   end

endmodule

`default_nettype wire

// ===== rtl/cbs_addr.sv =====
// ---------------------------------------------------------------------------
// Clipped blit setup - address generator
// Forms start addresses and copy sizes from the two clipped axes.
// ---------------------------------------------------------------------------
`default_nettype none

module cbs_addr
   import cbs_pkg::*;
(
   input  cfg_type         cfg,
   input  logic [31:0]     src_base,
   input  logic [15:0]     src_stride,
   input  axis_clip_type   clip_x,
   input  axis_clip_type   clip_y,
   output rsp_payload_type rsp
);

   logic        vis;
   logic [28:0] dst_row_ofs;
   logic [31:0] src_row_ofs;
   logic [31:0] dst_col_ofs;
   logic [31:0] src_col_ofs;
   logic [31:0] cnt_bytes;

   always_comb begin
      vis         = clip_x.ok && clip_y.ok;
      dst_row_ofs = cfg.dst_stride * clip_y.lo;
      src_row_ofs = src_stride * clip_y.off;
      dst_col_ofs = 32'(clip_x.lo)  * 32'(BYTES_PER_PIXEL);
      src_col_ofs = 32'(clip_x.off) * 32'(BYTES_PER_PIXEL);
      cnt_bytes   = 32'(clip_x.cnt) * 32'(BYTES_PER_PIXEL);

      rsp.visible   = vis;
      rsp.dst_start = vis ? cfg.dst_base + 32'(dst_row_ofs) + dst_col_ofs : 32'd0;
      rsp.src_start = vis ? src_base + src_row_ofs + src_col_ofs : 32'd0;
      rsp.row_bytes = vis ? cnt_bytes[13:0] : 14'd0;
      rsp.row_count = vis ? clip_y.cnt : 13'd0;
   end

endmodule

`default_nettype wire

// ===== verif/tb_clipped_blit_setup_unit.sv =====
// ---------------------------------------------------------------------------
// Clipped blit setup unit - testbench
// Drives blit requests through the request channel, predicts each response
// from a local model of the clip and address math, and checks the responses
// in order. Phases step through several destination settings and through
// runs with and without sender idling and response-side stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_clipped_blit_setup_unit;
   import cbs_pkg::*;

   localparam int CYCLE_LIMIT  = 200_000;   // far above the slowest legal run
   localparam int DRAIN_CYCLES = 6;         // extra wait once every response has been seen
   localparam int NUM_PHASES   = 8;
   localparam int MAX_REPORTS  = 10;

   logic            clock;
   logic            reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;

   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   logic            csr_valid = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index = CSR_DST_BASE;
   logic [31:0]     csr_data  = '0;

   // Requests not yet offered, and responses predicted but not yet seen
   req_payload_type pending_blits[$];
   rsp_payload_type expected_setups[$];

   // Local copy of the destination registers, as the block holds them
   cfg_type dest_cfg = '{dst_base: 32'd0, dst_width: 13'd640,
                         dst_height: 13'd480, dst_stride: 16'd1280};

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int mismatch_count = 0;
   int unexpected_count = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int visible_count  = 0;
   int cycle_count    = 0;

   clipped_blit_setup_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Prediction
   // -----------------------------------------------------------------------

   // Clip the span [p, p+n-1] to [0, lim-1]; zero when nothing is left.
   function automatic bit clip_span(input int p, input int n, input int lim,
                                    output int lo, output int hi);
      lo = p;
      hi = p + n - 1;
      if (n <= 0 || lim <= 0) return 1'b0;
      if (lo < 0) lo = 0;
      if (lo > lim - 1) return 1'b0;
      if (hi < 0) return 1'b0;
      if (hi > lim - 1) hi = lim - 1;
      return 1'b1;
   endfunction

   function automatic rsp_payload_type predict_blit(input req_payload_type r);
      rsp_payload_type s;
      int sw, sh, dw, dh, x, y, x0, x1, y0, y1;
      s  = '0;
      sw = r.src_width;
      sh = r.src_height;
      dw = dest_cfg.dst_width;
      dh = dest_cfg.dst_height;
      x  = r.pos_x;        // sign extends
      y  = r.pos_y;
      // Centered placement ignores the given position; int division
      // truncates toward zero, which is what the block must do.
      if (r.centered) begin
         x = (dw - sw) / 2;
         y = (dh - sh) / 2;
      end
      if (!clip_span(x, sw, dw, x0, x1)) return s;
      if (!clip_span(y, sh, dh, y0, y1)) return s;
      s.visible   = 1'b1;
      // Address sums are all kept at 32 bits, so they wrap like the hardware
      s.dst_start = dest_cfg.dst_base + dest_cfg.dst_stride * 32'(y0)
                  + 32'(x0) * 32'(BYTES_PER_PIXEL);
      s.src_start = r.src_base + r.src_stride * 32'(y0 - y)
                  + 32'(x0 - x) * 32'(BYTES_PER_PIXEL);
      s.row_bytes = 14'((x1 + 1 - x0) * BYTES_PER_PIXEL);
      s.row_count = 13'(y1 + 1 - y0);
      return s;
   endfunction

   // -----------------------------------------------------------------------
   // Request driver: offers queued requests, holds a stalled one steady,
   // and records the prediction for every request that gets accepted.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_setups.push_back(predict_blit(req_data));
            accepted_count++;
         end
         // Only move on once the current request is gone (or none is up)
         if (!req_valid || !req_stall) begin
            if (pending_blits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_blits.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Response monitor: checks every accepted response against the oldest
   // prediction and throws random stalls at the block.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      bit              bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_setups.size() == 0) begin
               unexpected_count++;
               if (mismatch_count + unexpected_count <= MAX_REPORTS)
                  $display("unexpected response: vis=%0b dst=%08h src=%08h bytes=%0d rows=%0d",
                           rsp_data.visible, rsp_data.dst_start, rsp_data.src_start,
                           rsp_data.row_bytes, rsp_data.row_count);
            end else begin
               want = expected_setups.pop_front();
               checked_count++;
               if (want.visible) visible_count++;
               bad = (rsp_data.visible   !== want.visible)   ||
                     (rsp_data.dst_start !== want.dst_start) ||
                     (rsp_data.src_start !== want.src_start) ||
                     (rsp_data.row_bytes !== want.row_bytes) ||
                     (rsp_data.row_count !== want.row_count);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count + unexpected_count <= MAX_REPORTS) begin
                     $display("response %0d mismatch", checked_count);
                     $display("  expected vis=%0b dst=%08h src=%08h bytes=%0d rows=%0d",
                              want.visible, want.dst_start, want.src_start,
                              want.row_bytes, want.row_count);
                     $display("  actual   vis=%0b dst=%08h src=%08h bytes=%0d rows=%0d",
                              rsp_data.visible, rsp_data.dst_start, rsp_data.src_start,
                              rsp_data.row_bytes, rsp_data.row_count);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_setups.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus helpers
   // -----------------------------------------------------------------------

   // One register write; the shadow copy follows once the write is taken.
   task automatic write_dest_reg(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DST_BASE:   dest_cfg.dst_base   = val;
         CSR_DST_WIDTH:  dest_cfg.dst_width  = val[12:0];
         CSR_DST_HEIGHT: dest_cfg.dst_height = val[12:0];
         CSR_DST_STRIDE: dest_cfg.dst_stride = val[15:0];
      endcase
   endtask

   task automatic set_destination(input logic [31:0] base, input int w, input int h,
                                  input int stride);
      write_dest_reg(CSR_DST_BASE,   base);
      write_dest_reg(CSR_DST_WIDTH,  32'(w));
      write_dest_reg(CSR_DST_HEIGHT, 32'(h));
      write_dest_reg(CSR_DST_STRIDE, 32'(stride));
   endtask

   // Block until every queued request went in and every response came out,
   // then wait for the pipeline to settle.
   task automatic wait_drained();
      while (pending_blits.size() != 0 || req_valid || expected_setups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_payload_type blit_req(input logic [31:0] base, input int w,
                                                input int h, input int stride,
                                                input int x, input int y, input bit c);
      req_payload_type r;
      r.src_base   = base;
      r.src_width  = 13'(w);
      r.src_height = 13'(h);
      r.src_stride = 16'(stride);
      r.pos_x      = 16'(x);
      r.pos_y      = 16'(y);
      r.centered   = c;
      return r;
   endfunction

   // Source extent along one axis: mostly small, sometimes around the
   // destination size, now and then zero or beyond the nominal range.
   function automatic int random_extent(input int lim);
      case ($urandom_range(15))
         0:       return 0;
         1:       return $urandom_range(8191);
         2:       return 8191;
         3, 4:    return $urandom_range(1, (lim + lim / 2 + 2 > 8191) ? 8191
                                                                    : lim + lim / 2 + 2);
         default: return $urandom_range(1, 48);
      endcase
   endfunction

   // Placement along one axis, biased to straddle either edge
   function automatic int random_origin(input int lim, input int n);
      case ($urandom_range(7))
         0:       return int'($urandom_range(65535)) - 32768;
         1, 2:    return int'($urandom_range(2 * n + 2)) - n - 1;
         3, 4:    return lim - n - 1 + int'($urandom_range(2 * n + 2));
         default: return $urandom_range(lim);
      endcase
   endfunction

   function automatic req_payload_type random_blit_request();
      int w, h;
      w = random_extent(dest_cfg.dst_width);
      h = random_extent(dest_cfg.dst_height);
      return blit_req($urandom, w, h, $urandom_range(65535),
                      random_origin(dest_cfg.dst_width, w),
                      random_origin(dest_cfg.dst_height, h),
                      $urandom_range(3) == 0);
   endfunction

   // -----------------------------------------------------------------------
   // Test sequence
   // -----------------------------------------------------------------------
   initial begin
      int n_items;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // Idle pattern rotates: none, sender gaps, response stalls, light mix
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
         endcase

         // Destination settings; the first phase runs on the reset values
         case (ph)
            1: set_destination(32'hFFFF_FFFF, 1, 1, 0);
            2: set_destination($urandom, 4096, 4096, 65535);
            3: set_destination($urandom, 8191, 8191, $urandom_range(65535));
            4: set_destination(32'd0, 0, $urandom_range(1, 600), 1280);
            5: set_destination($urandom, $urandom_range(1, 800), 0,
                               $urandom_range(1, 65535));
            6: set_destination($urandom, $urandom_range(1, 4096), $urandom_range(1, 4096),
                               $urandom_range(1, 65535));
            7: set_destination($urandom, $urandom_range(1, 64), $urandom_range(1, 64),
                               $urandom_range(1, 256));
            default: ;
         endcase

         if (ph == 0) begin
            // Directed cases against the 640x480 reset destination
            pending_blits.push_back(blit_req(32'd0, 0, 0, 0, 0, 0, 1'b0));
            pending_blits.push_back(blit_req(32'h1000, 0, 10, 64, 5, 5, 1'b0));
            pending_blits.push_back(blit_req(32'h1000, 10, 0, 64, 5, 5, 1'b0));
            // fully inside
            pending_blits.push_back(blit_req(32'h8000_0000, 100, 50, 200, 10, 20, 1'b0));
            // cut on the left and top, then on the right and bottom
            pending_blits.push_back(blit_req(32'h2000, 20, 20, 40, -5, -7, 1'b0));
            pending_blits.push_back(blit_req(32'h2000, 20, 20, 40, 630, 470, 1'b0));
            // entirely off each side, one pixel short of touching
            pending_blits.push_back(blit_req(32'h3000, 20, 10, 40, -20, 0, 1'b0));
            pending_blits.push_back(blit_req(32'h3000, 20, 10, 40, 640, 0, 1'b0));
            pending_blits.push_back(blit_req(32'h3000, 10, 30, 20, 0, -30, 1'b0));
            pending_blits.push_back(blit_req(32'h3000, 10, 30, 20, 0, 480, 1'b0));
            // single pixels in opposite corners
            pending_blits.push_back(blit_req(32'h4000, 1, 1, 2, 639, 479, 1'b0));
            pending_blits.push_back(blit_req(32'h4000, 1, 1, 2, 0, 0, 1'b0));
            // oversized source covering everything, with wrapping addresses
            pending_blits.push_back(blit_req(32'hFFFF_FFFF, 8191, 8191, 65535,
                                             -100, -100, 1'b0));
            // position extremes
            pending_blits.push_back(blit_req(32'h5000, 8191, 8191, 16384,
                                             -32768, -32768, 1'b0));
            pending_blits.push_back(blit_req(32'h5000, 8191, 8191, 16384,
                                             32767, 32767, 1'b0));
            pending_blits.push_back(blit_req(32'h5000, 100, 100, 200, -32768, 32767, 1'b0));
            // centered: even, odd and negative differences (truncation toward zero)
            pending_blits.push_back(blit_req(32'h6000, 100, 50, 200, 0, 0, 1'b1));
            pending_blits.push_back(blit_req(32'h6000, 101, 51, 202, 0, 0, 1'b1));
            pending_blits.push_back(blit_req(32'h6000, 1001, 481, 2002, 0, 0, 1'b1));
            pending_blits.push_back(blit_req(32'hFFFF_0000, 8191, 8191, 65535,
                                             0, 0, 1'b1));
            // centered with a position that must be ignored
            pending_blits.push_back(blit_req(32'h7000, 64, 64, 128, -32768, 32767, 1'b1));
            pending_blits.push_back(blit_req(32'h7000, 640, 480, 1280, 5, 5, 1'b1));
         end

         // Zero-size destinations clip everything, so keep those phases short
         n_items = (ph == 4 || ph == 5) ? 60 : 260;
         for (int i = 0; i < n_items; i++)
            pending_blits.push_back(random_blit_request());

         wait_drained();
      end

      $display("Checked %0d blit setups (%0d visible, %0d clipped away) over %0d",
               checked_count, visible_count, checked_count - visible_count, NUM_PHASES);
      $display("destination settings, with and without request gaps and response stalls");
      if (mismatch_count == 0 && unexpected_count == 0 && expected_setups.size() == 0 &&
          accepted_count == checked_count) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_clip_axis.sv
rtl/cbs_addr.sv
rtl/clipped_blit_setup_unit.sv
verif/tb_clipped_blit_setup_unit.sv
